[sv/lzw12_pkg.sv]
// Shared constants for the 12-bit LZW decoder.
// No dependencies; imported by the dictionary, the stack, the top level and the testbench.
package lzw12_pkg;

	// Field widths of the packed code stream.
	localparam int BYTE_W     = 8;
	localparam int CODE_W     = 12;
	localparam int NIB_W      = 4;
	localparam logic [BYTE_W-1:0] LO_NIB_MASK = 8'h0F;

	// Implicit single-byte roots of the dictionary.
	localparam int ROOT_CODES = 256;

	// Default sizing.
	localparam int DEF_DICT_SIZE      = 4096;
	localparam int DEF_MAX_STRING_LEN = 64;

endpackage

[sv/lzw_decoder_12bit.sv]
// LZW decoder for 12-bit codes packed two to three bytes, one decoded byte per output item.
// Uses lzw12_pkg, the lzw12_dict dictionary and the lzw12_stack output stack.
// A byte that completes no code passes only through the finish state. A completed code is looked up,
// checked, its prefix chain walked into the stack one entry at a time, and its bytes then read from
// the stack in order; the input stays stalled until the last byte is out. One item is in work at a time.
// Reset (arst_n low, or an item with in_last once its results are out) restores the 256 roots.
module lzw_decoder_12bit #(
	parameter int DICT_SIZE      = lzw12_pkg::DEF_DICT_SIZE,
	parameter int MAX_STRING_LEN = lzw12_pkg::DEF_MAX_STRING_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lzw12_pkg::BYTE_W-1:0]  in_byte,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lzw12_pkg::BYTE_W-1:0]  out_byte,
	output logic                          out_last,
	output logic                          out_error
);
	import lzw12_pkg::*;

	localparam int AW    = $clog2(DICT_SIZE);
	localparam int NFC_W = $clog2(DICT_SIZE + 1);
	localparam int LEN_W = $clog2(MAX_STRING_LEN + 2);
	localparam int SP_W  = $clog2(MAX_STRING_LEN);
	localparam int CMP_W = CODE_W + 1;

	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_DECIDE, S_WALK, S_STEP, S_EMIT_RD, S_EMIT_WR, S_ERR, S_FINISH
	} state_t;

	state_t              state_q;
	logic [1:0]          phase_q;
	logic [BYTE_W-1:0]   held_q;
	logic                aborted_q;
	logic                last_q;
	logic [CODE_W-1:0]   code_q;
	logic [NFC_W-1:0]    nfc_q;
	logic [AW-1:0]       prev_code_q;
	logic [BYTE_W-1:0]   prev_first_q;
	logic [LEN_W-1:0]    prev_len_q;
	logic                have_prev_q;
	logic [AW-1:0]       cur_q;
	logic [LEN_W-1:0]    pos_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_last_q;
	logic                out_error_q;

	// Dictionary and stack port signals.
	logic                dict_we;
	logic [AW-1:0]       dict_raddr;
	logic [AW-1:0]       rd_prefix;
	logic [BYTE_W-1:0]   rd_suffix;
	logic [BYTE_W-1:0]   rd_first;
	logic [LEN_W-1:0]    rd_len;
	logic                stk_we;
	logic [SP_W-1:0]     stk_waddr;
	logic [BYTE_W-1:0]   stk_wdata;
	logic [BYTE_W-1:0]   stk_rdata;

	// Decode decision signals.
	logic                code_root;
	logic                cur_root;
	logic                dict_open;
	logic                case_a;
	logic                case_b;
	logic [LEN_W-1:0]    len_a;
	logic [BYTE_W-1:0]   first_a;
	logic [LEN_W-1:0]    len_sel;
	logic [BYTE_W-1:0]   first_sel;
	logic [LEN_W-1:0]    prev_len_inc;
	logic                dec_ok;
	logic                out_free;
	logic                out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_error = out_error_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_EMIT_WR) || (state_q == S_ERR)) && out_free;

	// Classify the completed code against the dictionary state.
	always_comb begin
		code_root    = (code_q < CODE_W'(ROOT_CODES));
		cur_root     = (cur_q < AW'(ROOT_CODES));
		dict_open    = (nfc_q < NFC_W'(DICT_SIZE));
		case_a       = ({1'b0, code_q} < CMP_W'(nfc_q)) && (have_prev_q || code_root);
		case_b       = have_prev_q && ({1'b0, code_q} == CMP_W'(nfc_q)) && dict_open;
		len_a        = code_root ? LEN_W'(1) : rd_len;
		first_a      = code_root ? code_q[BYTE_W-1:0] : rd_first;
		prev_len_inc = prev_len_q + LEN_W'(1);
		len_sel      = case_a ? len_a : prev_len_inc;
		first_sel    = case_a ? first_a : prev_first_q;
		dec_ok       = (case_a || case_b) && (len_sel <= LEN_W'(MAX_STRING_LEN));
	end

	// Dictionary port control: a clean decode after the first adds an entry while there is room.
	always_comb begin
		dict_we    = (state_q == S_DECIDE) && dec_ok && have_prev_q && dict_open;
		dict_raddr = (state_q == S_LOOK) ? code_q[AW-1:0] : cur_q;
	end

	// Stack writes: the tail byte of a not-yet-defined code, chain roots and chain suffixes.
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = SP_W'(pos_q - LEN_W'(1));
		stk_wdata = rd_suffix;
		unique case (state_q)
			S_DECIDE: begin
				stk_we    = dec_ok && !case_a;
				stk_waddr = SP_W'(len_sel - LEN_W'(1));
				stk_wdata = prev_first_q;
			end
			S_WALK: begin
				stk_we    = (pos_q != '0) && cur_root;
				stk_wdata = cur_q[BYTE_W-1:0];
			end
			S_STEP: begin
				stk_we = 1'b1;
			end
			default: begin
				stk_we = 1'b0;
			end
		endcase
	end

	lzw12_dict #(
		.DICT_SIZE (DICT_SIZE),
		.LEN_W     (LEN_W)
	) u_dict (
		.clk     (clk),
		.we      (dict_we),
		.waddr   (nfc_q[AW-1:0]),
		.wprefix (prev_code_q),
		.wsuffix (first_sel),
		.wfirst  (prev_first_q),
		.wlen    (prev_len_inc),
		.raddr   (dict_raddr),
		.rprefix (rd_prefix),
		.rsuffix (rd_suffix),
		.rfirst  (rd_first),
		.rlen    (rd_len)
	);

	lzw12_stack #(
		.MAX_STRING_LEN (MAX_STRING_LEN)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (idx_q[SP_W-1:0]),
		.rdata (stk_rdata)
	);

	// Sequencer: unpack, decide, walk the prefix chain, emit the string or an error item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_EMPTY;
			held_q       <= '0;
			aborted_q    <= 1'b0;
			last_q       <= 1'b0;
			code_q       <= '0;
			nfc_q        <= NFC_W'(ROOT_CODES);
			prev_code_q  <= '0;
			prev_first_q <= '0;
			prev_len_q   <= '0;
			have_prev_q  <= 1'b0;
			cur_q        <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_error_q  <= 1'b0;
		end else begin
			// The output register holds its item until the receiver takes it.
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= in_last;
						if (aborted_q) begin
							state_q <= S_FINISH;
						end else begin
							unique case (phase_q)
								PH_FIRST: begin
									code_q  <= {held_q, in_byte[BYTE_W-1:NIB_W]};
									held_q  <= in_byte & LO_NIB_MASK;
									phase_q <= PH_SECOND;
									state_q <= S_LOOK;
								end
								PH_SECOND: begin
									code_q  <= {held_q[NIB_W-1:0], in_byte};
									held_q  <= '0;
									phase_q <= PH_EMPTY;
									state_q <= S_LOOK;
								end
								default: begin
									held_q  <= in_byte;
									phase_q <= PH_FIRST;
									state_q <= S_FINISH;
								end
							endcase
						end
					end
				end
				S_LOOK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!dec_ok) begin
						state_q <= S_ERR;
					end else begin
						if (have_prev_q && dict_open) begin
							nfc_q <= nfc_q + NFC_W'(1);
						end
						prev_code_q  <= code_q[AW-1:0];
						prev_first_q <= first_sel;
						prev_len_q   <= len_sel;
						have_prev_q  <= 1'b1;
						len_q        <= len_sel;
						if (case_a) begin
							cur_q <= code_q[AW-1:0];
							pos_q <= len_sel;
						end else begin
							cur_q <= prev_code_q;
							pos_q <= len_sel - LEN_W'(1);
						end
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (pos_q == '0) begin
						idx_q   <= '0;
						state_q <= S_EMIT_RD;
					end else if (cur_root) begin
						cur_q <= '0;
						pos_q <= pos_q - LEN_W'(1);
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					cur_q   <= rd_prefix;
					pos_q   <= pos_q - LEN_W'(1);
					state_q <= S_WALK;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (out_free) begin
						out_byte_q  <= stk_rdata;
						out_last_q  <= (idx_q + LEN_W'(1) == len_q);
						out_error_q <= 1'b0;
						if (idx_q + LEN_W'(1) == len_q) begin
							state_q <= S_FINISH;
						end else begin
							idx_q   <= idx_q + LEN_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						out_byte_q  <= '0;
						out_last_q  <= 1'b1;
						out_error_q <= 1'b1;
						aborted_q   <= 1'b1;
						state_q     <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (last_q) begin
						phase_q      <= PH_EMPTY;
						held_q       <= '0;
						aborted_q    <= 1'b0;
						nfc_q        <= NFC_W'(ROOT_CODES);
						prev_code_q  <= '0;
						prev_first_q <= '0;
						prev_len_q   <= '0;
						have_prev_q  <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/lzw12_dict.sv]
// Dictionary memory of the LZW decoder: prefix, suffix, first byte and length per code.
// One write port and one read port with registered read data.
// Depends on lzw12_pkg.
module lzw12_dict #(
	parameter int DICT_SIZE = lzw12_pkg::DEF_DICT_SIZE,
	parameter int LEN_W     = 7
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DICT_SIZE)-1:0]  waddr,
	input  logic [$clog2(DICT_SIZE)-1:0]  wprefix,
	input  logic [lzw12_pkg::BYTE_W-1:0]  wsuffix,
	input  logic [lzw12_pkg::BYTE_W-1:0]  wfirst,
	input  logic [LEN_W-1:0]              wlen,
	input  logic [$clog2(DICT_SIZE)-1:0]  raddr,
	output logic [$clog2(DICT_SIZE)-1:0]  rprefix,
	output logic [lzw12_pkg::BYTE_W-1:0]  rsuffix,
	output logic [lzw12_pkg::BYTE_W-1:0]  rfirst,
	output logic [LEN_W-1:0]              rlen
);
	import lzw12_pkg::*;

	localparam int AW    = $clog2(DICT_SIZE);
	localparam int ENT_W = AW + 2 * BYTE_W + LEN_W;

	logic [ENT_W-1:0] mem_q [DICT_SIZE];
	logic [ENT_W-1:0] rd_q;

	// Entries are written when a code is added and read for the code lookup and the chain walk.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {wprefix, wsuffix, wfirst, wlen};
		end
		rd_q <= mem_q[raddr];
	end

	assign {rprefix, rsuffix, rfirst, rlen} = rd_q;

endmodule

[sv/lzw12_decoder_12bit_placeholder.sv]
// Output string stack of the LZW decoder, one write and one registered read per cycle.
// Depends on lzw12_pkg.
module lzw12_stack #(
	parameter int MAX_STRING_LEN = lzw12_pkg::DEF_MAX_STRING_LEN
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(MAX_STRING_LEN)-1:0]   waddr,
	input  logic [lzw12_pkg::BYTE_W-1:0]        wdata,
	input  logic [$clog2(MAX_STRING_LEN)-1:0]   raddr,
	output logic [lzw12_pkg::BYTE_W-1:0]        rdata
);
	import lzw12_pkg::*;

	logic [BYTE_W-1:0] mem_q [MAX_STRING_LEN];
	logic [BYTE_W-1:0] rd_q;

	// The chain walk fills the string from its end; emission reads it from the front.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

[verif/tb_lzw_decoder_12bit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lzw_decoder_12bit: packed 12-bit code bytes in, decoded bytes out.
// Needs lzw12_pkg and the decoder RTL; holds its own LZW dictionary model to predict each item.
module tb_lzw_decoder_12bit;

	import lzw12_pkg::*;

	localparam int DICT_N       = DEF_DICT_SIZE;
	localparam int STR_MAX      = DEF_MAX_STRING_LEN;
	localparam int SPELL_IW     = $clog2(STR_MAX);
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 400;

	// One decoded output item.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              fin;
		logic              err;
	} dec_out_t;

	// One input item, with an optional expectation written by hand.
	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              l;
		logic              typed;
		dec_out_t          want;
	} stim_row_t;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              l;
	} plan_t;

	typedef enum {STY_NORMAL, STY_CHAIN, STY_NOISE} stream_style_t;
	typedef enum logic [1:0] {PH_BYTE_A, PH_BYTE_B, PH_BYTE_C} unpack_phase_t;

	localparam dec_out_t NO_OUT  = '{8'h00, 1'b0, 1'b0};
	localparam dec_out_t ERR_OUT = '{8'h00, 1'b1, 1'b1};

	// Directed streams: basic roots and the not-yet-defined code, a first code above the
	// roots, a code beyond the next free entry, and in_last on each byte position.
	localparam int DIR_COUNT = 21;
	localparam int ROW_IW    = $clog2(DIR_COUNT);
	localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
		'{8'h00, 1'b0, 1'b0, NO_OUT},
		'{8'h01, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{8'h00, 1'b0, 1'b0, NO_OUT},
		'{8'h0F, 1'b0, 1'b0, NO_OUT},
		'{8'hF1, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{8'h01, 1'b0, 1'b0, NO_OUT},
		'{8'hAB, 1'b1, 1'b0, NO_OUT},
		'{8'hFF, 1'b0, 1'b0, NO_OUT},
		'{8'hF0, 1'b0, 1'b1, ERR_OUT},
		'{8'h12, 1'b0, 1'b0, NO_OUT},
		'{8'h34, 1'b0, 1'b0, NO_OUT},
		'{8'h56, 1'b1, 1'b0, NO_OUT},
		'{8'h04, 1'b0, 1'b0, NO_OUT},
		'{8'h11, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},
		'{8'h02, 1'b0, 1'b1, ERR_OUT},
		'{8'h00, 1'b1, 1'b0, NO_OUT},
		'{8'h0A, 1'b0, 1'b0, NO_OUT},
		'{8'hA5, 1'b1, 1'b1, '{8'hAA, 1'b1, 1'b0}},
		'{8'h05, 1'b0, 1'b0, NO_OUT},
		'{8'h50, 1'b0, 1'b1, '{8'h55, 1'b1, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              in_last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic              out_error;

	// Hand-written expectation travelling with the item on the input.
	logic     cur_typed = 1'b0;
	dec_out_t cur_want = NO_OUT;

	dec_out_t due_bytes[$];
	plan_t    plan_q[$];
	int       fail_cnt = 0;
	int       results_seen = 0;
	int       send_calm = 0;

	// Dictionary model: chain link, last byte, first byte and string length per entry.
	logic [CODE_W-1:0] link_mem [DICT_N];
	logic [BYTE_W-1:0] tail_mem [DICT_N];
	logic [BYTE_W-1:0] head_mem [DICT_N];
	logic [6:0]        span_mem [DICT_N];
	logic [BYTE_W-1:0] spell [STR_MAX];
	int unsigned       free_code;
	logic [CODE_W-1:0] last_code;
	logic [BYTE_W-1:0] last_head;
	bit                have_last;
	unpack_phase_t     phase;
	logic [BYTE_W-1:0] held;
	bit                dead;

	lzw_decoder_12bit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last),
		.out_error(out_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state after reset or after an item with in_last.
	task automatic clear_model();
		free_code = ROOT_CODES;
		last_code = '0;
		last_head = '0;
		have_last = 1'b0;
		phase = PH_BYTE_A;
		held = '0;
		dead = 1'b0;
	endtask

	function automatic int unsigned span_of(input logic [CODE_W-1:0] c);
		return (c < ROOT_CODES) ? 1 : 32'(span_mem[c]);
	endfunction

	function automatic logic [BYTE_W-1:0] head_of(input logic [CODE_W-1:0] c);
		return (c < ROOT_CODES) ? c[BYTE_W-1:0] : head_mem[c];
	endfunction

	// Walk the prefix chain from the end of the string back to its root.
	task automatic spell_out(input logic [CODE_W-1:0] c, input int unsigned n);
		logic [CODE_W-1:0] cur;
		int pos;
		cur = c;
		for (pos = int'(n) - 1; pos >= 0; pos--) begin
			if (cur < ROOT_CODES) begin
				spell[SPELL_IW'(pos)] = cur[BYTE_W-1:0];
				cur = '0;
			end else begin
				spell[SPELL_IW'(pos)] = tail_mem[cur];
				cur = link_mem[cur];
			end
		end
	endtask

	task automatic flag_error();
		dead = 1'b1;
		due_bytes.push_back(ERR_OUT);
	endtask

	// Decode one completed code and queue the bytes of its string.
	task automatic decode_code(input logic [CODE_W-1:0] c);
		int unsigned n;
		int unsigned grown;
		logic [BYTE_W-1:0] lead;
		int i;
		if (c < ROOT_CODES || (have_last && 32'(c) < free_code)) begin
			n = span_of(c);
			if (n > STR_MAX) begin
				flag_error();
				return;
			end
			spell_out(c, n);
			lead = head_of(c);
		end else if (have_last && 32'(c) == free_code && free_code < DICT_N) begin
			// The code that is being defined right now: previous string plus its first byte.
			n = span_of(last_code) + 1;
			if (n > STR_MAX) begin
				flag_error();
				return;
			end
			spell_out(last_code, n - 1);
			spell[SPELL_IW'(n - 1)] = last_head;
			lead = last_head;
		end else begin
			flag_error();
			return;
		end

		// Grow the dictionary until it is full; lengths saturate one past the limit.
		if (have_last && free_code < DICT_N) begin
			grown = span_of(last_code) + 1;
			if (grown > STR_MAX + 1)
				grown = STR_MAX + 1;
			link_mem[CODE_W'(free_code)] = last_code;
			tail_mem[CODE_W'(free_code)] = lead;
			head_mem[CODE_W'(free_code)] = last_head;
			span_mem[CODE_W'(free_code)] = grown[6:0];
			free_code++;
		end
		last_code = c;
		last_head = lead;
		have_last = 1'b1;

		for (i = 0; i < int'(n); i++)
			due_bytes.push_back('{spell[SPELL_IW'(i)], (i == int'(n) - 1), 1'b0});
	endtask

	// Unpack one input byte; every second and third byte of a group completes a code.
	task automatic take_byte(input logic [BYTE_W-1:0] b, input logic l);
		if (!dead) begin
			case (phase)
				PH_BYTE_B: begin
					phase = PH_BYTE_C;
					decode_code({held, b[7:4]});
					held = b & LO_NIB_MASK;
				end
				PH_BYTE_C: begin
					phase = PH_BYTE_A;
					decode_code({held[NIB_W-1:0], b});
					held = '0;
				end
				default: begin
					held = b;
					phase = PH_BYTE_B;
				end
			endcase
		end
		if (l)
			clear_model();
	endtask

	// Accepted inputs feed the model first, then accepted outputs are checked in order.
	always @(posedge clk) begin
		int mark;
		dec_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				mark = due_bytes.size();
				take_byte(in_byte, in_last);
				if (cur_typed) begin
					while (due_bytes.size() > mark)
						void'(due_bytes.pop_back());
					due_bytes.push_back(cur_want);
				end
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_bytes.size() == 0) begin
					$error("unexpected item: out_byte %0h out_last %0b out_error %0b",
						out_byte, out_last, out_error);
					fail_cnt++;
				end else begin
					want = due_bytes.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0h, got %0h", want.data, out_byte);
						fail_cnt++;
					end
					if (out_last !== want.fin) begin
						$error("out_last: expected %0b, got %0b", want.fin, out_last);
						fail_cnt++;
					end
					if (out_error !== want.err) begin
						$error("out_error: expected %0b, got %0b", want.err, out_error);
						fail_cnt++;
					end
				end
			end
		end
	end

	// Sender gaps: mostly none or short, a few long, and calm stretches with none.
	function automatic int pick_gap();
		int unsigned r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 8)
			return $urandom_range(10, 40);
		if (r < 40)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// Offer one item from a falling edge and return at the falling edge after it is taken.
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic l, input logic typed,
			input dec_out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_byte <= b;
		in_last <= l;
		cur_typed <= typed;
		cur_want <= want;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [BYTE_W-1:0] b);
		plan_q.push_back('{b, 1'b0});
	endtask

	// Mostly codes the dictionary already knows, some not-yet-defined ones, rare invalid ones.
	function automatic logic [CODE_W-1:0] pick_code(input int unsigned free_est, input bit opening);
		int unsigned r;
		int unsigned reach;
		r = $urandom_range(0, 99);
		if (r >= 97) begin
			if (free_est < DICT_N - 1)
				return CODE_W'($urandom_range(free_est + 1, DICT_N - 1));
			return CODE_W'($urandom_range(0, ROOT_CODES - 1));
		end
		if (opening || r < 30)
			return CODE_W'($urandom_range(0, ROOT_CODES - 1));
		if (r < 46 && free_est < DICT_N)
			return CODE_W'(free_est);
		if (free_est == ROOT_CODES)
			return CODE_W'($urandom_range(0, ROOT_CODES - 1));
		if (r < 80) begin
			reach = free_est - ROOT_CODES - 1;
			if (reach > 15)
				reach = 15;
			return CODE_W'(free_est - 1 - $urandom_range(0, reach));
		end
		return CODE_W'($urandom_range(ROOT_CODES, free_est - 1));
	endfunction

	// Build one stream of items; the last one carries in_last.
	task automatic plan_stream(input stream_style_t style, input int n_codes, input bit tail);
		logic [CODE_W-1:0] codes[$];
		logic [CODE_W-1:0] c;
		int unsigned free_est;
		int run;
		int k;
		free_est = ROOT_CODES;
		run = $urandom_range(60, 66);
		if (style == STY_NOISE) begin
			for (k = 0; k < n_codes; k++)
				add_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			for (k = 0; k < n_codes; k++) begin
				if (style == STY_CHAIN && k <= run + 2) begin
					// A run of not-yet-defined codes grows the string by one byte each,
					// then a root and the newest entry, which can pass the length limit.
					if (k == 0 || k == run + 1)
						c = CODE_W'($urandom_range(0, ROOT_CODES - 1));
					else if (k <= run)
						c = CODE_W'(free_est);
					else
						c = CODE_W'(free_est - 1);
				end else begin
					c = pick_code(free_est, k == 0);
				end
				codes.push_back(c);
				if (k > 0 && free_est < DICT_N)
					free_est++;
			end
			// Two codes fill three bytes; an odd code out leaves a random low nibble.
			for (k = 0; k < codes.size(); k += 2) begin
				add_byte(codes[k][11:4]);
				if (k + 1 < codes.size()) begin
					add_byte({codes[k][3:0], codes[k+1][11:8]});
					add_byte(codes[k+1][7:0]);
				end else begin
					add_byte({codes[k][3:0], 4'($urandom_range(0, 15))});
				end
			end
			if (tail)
				add_byte(BYTE_W'($urandom_range(0, 255)));
		end
		plan_q[plan_q.size()-1].l = 1'b1;
	endtask

	task automatic plan_random(input int target);
		int start;
		int unsigned r;
		start = plan_q.size();
		while (plan_q.size() - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				plan_stream(STY_NORMAL, $urandom_range(2, 40), $urandom_range(0, 3) == 0);
			else if (r < 80)
				plan_stream(STY_CHAIN, $urandom_range(66, 72), 1'b0);
			else
				plan_stream(STY_NOISE, $urandom_range(3, 12), 1'b0);
		end
	endtask

	// Receiver: random stalls, quiet stretches, and one long hold that backs up the input.
	initial begin
		int stall_left;
		int free_left;
		int unsigned r;
		bit held_off;
		stall_left = 0;
		free_left = 0;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && free_left == 0) begin
				r = $urandom_range(0, 99);
				if (!held_off && results_seen >= 40) begin
					held_off = 1'b1;
					stall_left = HOLD_CYCLES;
					free_left = 1;
				end else if (r < 8) begin
					free_left = $urandom_range(40, 150);
				end else if (r < 11) begin
					stall_left = $urandom_range(10, 40);
					free_left = 1;
				end else begin
					stall_left = $urandom_range(0, 3);
					free_left = $urandom_range(1, 4);
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				free_left--;
			end
		end
	end

	// Run limit.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// Reset, directed table, random streams, then drain.
	initial begin
		int k;
		clear_model();
		plan_random(450);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIR_COUNT; k++)
			send_item(DIR_ROWS[ROW_IW'(k)].b, DIR_ROWS[ROW_IW'(k)].l,
				DIR_ROWS[ROW_IW'(k)].typed, DIR_ROWS[ROW_IW'(k)].want);
		for (k = 0; k < plan_q.size(); k++)
			send_item(plan_q[k].b, plan_q[k].l, 1'b0, NO_OUT);
		in_valid <= 1'b0;
		cur_typed <= 1'b0;

		while (due_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_cnt == 0 && due_bytes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
